@@ sv/rrea_pkg.sv @@
// shared types and constants for the round robin egress arbiter
// no dependencies; imported by rrea_pick and round_robin_egress_arbiter_core
package rrea_pkg;

    localparam int MASK_W      = 8;
    localparam int QUEUE_W     = 3;
    localparam int MAX_QUEUES  = 8;
    localparam int KIND_W      = 2;
    localparam int SIZE_W      = 14;
    localparam int COUNT_W     = 25;
    localparam int BYTES_W     = 15;
    localparam int TPB_W       = 11;
    localparam int QCOUNT_W    = 4;
    localparam int BYTE_CFG_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [TPB_W-1:0] TPB_MAX = TPB_W'(1024);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LEVEL_RESP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEVEL_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME        = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK         = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_QUEUES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERHEAD_BYTES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_BYTES      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_BYTE = 3'd3;

    // register reset values
    localparam logic [QCOUNT_W-1:0]   ACTIVE_QUEUES_RST  = 4'd8;
    localparam logic [BYTE_CFG_W-1:0] OVERHEAD_BYTES_RST = 8'd8;
    localparam logic [BYTE_CFG_W-1:0] GAP_BYTES_RST      = 8'd12;
    localparam logic [TPB_W-1:0]      TICKS_PER_BYTE_RST = 11'd8;
    localparam logic [QUEUE_W-1:0]    LAST_WINNER_RST    = 3'd7;

    typedef struct packed {
        logic               hit;
        logic [QUEUE_W-1:0] queue;
    } pick_t;

endpackage

@@ sv/rrea_pick.sv @@
// round robin queue pick over the active part of the non-empty mask
// depends on rrea_pkg
module rrea_pick (
    input  logic [rrea_pkg::MASK_W-1:0]   req,
    input  logic [rrea_pkg::QUEUE_W-1:0]  last_winner,
    input  logic [rrea_pkg::QCOUNT_W-1:0] active_queues,
    output rrea_pkg::pick_t               pick
);
    import rrea_pkg::*;

    logic [QCOUNT_W-1:0] queue_cnt;
    logic [QCOUNT_W-1:0] start_plus;
    logic [QUEUE_W-1:0]  start;
    logic [MASK_W-1:0]   req_act;
    logic [MASK_W-1:0]   req_hi;
    logic                hi_hit;
    logic [QUEUE_W-1:0]  hi_idx;
    logic                any_hit;
    logic [QUEUE_W-1:0]  any_idx;

    always_comb
    begin
        queue_cnt = active_queues;
        if (queue_cnt < QCOUNT_W'(1))
        begin
            queue_cnt = QCOUNT_W'(1);
        end
        if (queue_cnt > QCOUNT_W'(MAX_QUEUES))
        begin
            queue_cnt = QCOUNT_W'(MAX_QUEUES);
        end
        if (queue_cnt > QCOUNT_W'(MASK_W))
        begin
            queue_cnt = QCOUNT_W'(MASK_W);
        end

        start_plus = QCOUNT_W'(last_winner) + QCOUNT_W'(1);
        start      = (start_plus >= queue_cnt) ? '0 : start_plus[QUEUE_W-1:0];

        // drop queues beyond the active count, then split at the start point
        for (int i = 0; i < MASK_W; i++)
        begin
            req_act[i] = req[i] && (QCOUNT_W'(i) < queue_cnt);
            req_hi[i]  = req_act[i] && (QUEUE_W'(i) >= start);
        end

        hi_hit  = 1'b0;
        hi_idx  = '0;
        any_hit = 1'b0;
        any_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (req_hi[i])
            begin
                hi_hit = 1'b1;
                hi_idx = QUEUE_W'(i);
            end
            if (req_act[i])
            begin
                any_hit = 1'b1;
                any_idx = QUEUE_W'(i);
            end
        end

        // wrap to the lowest active request when nothing at or above start
        pick.hit   = any_hit;
        pick.queue = hi_hit ? hi_idx : any_idx;
    end

endmodule

@@ sv/round_robin_egress_arbiter_core.sv @@
// Round robin egress arbiter core: takes one item per clock while in_stall
// is low and returns one result per item, registered, in the cycle after
// the input transfer. The arbitration pick, the frame-time multiply and the
// countdown step are all combinational between the state registers and the
// result register, which takes a new item in the same cycle that its
// previous result is taken; in_stall rises only when it is full and stalled.
// Depends on rrea_pkg and rrea_pick.
module round_robin_egress_arbiter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrea_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rrea_pkg::KIND_W-1:0]      kind,
    input  logic [rrea_pkg::MASK_W-1:0]      queue_nonempty,
    input  logic [rrea_pkg::SIZE_W-1:0]      frame_size,
    // results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             grant_valid,
    output logic [rrea_pkg::QUEUE_W-1:0]     grant_queue,
    output logic                             frame_release,
    output logic                             level_request,
    output logic                             busy_now
);
    import rrea_pkg::*;

    logic [QCOUNT_W-1:0]   active_queues_reg;
    logic [BYTE_CFG_W-1:0] overhead_bytes_reg;
    logic [BYTE_CFG_W-1:0] gap_bytes_reg;
    logic [TPB_W-1:0]      ticks_per_byte_reg;

    logic [QUEUE_W-1:0]    last_winner_reg, last_winner_next;
    logic                  busy_reg, busy_next;
    logic                  waiting_reg, waiting_next;
    logic [COUNT_W-1:0]    countdown_reg, countdown_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  grant_valid_reg, grant_valid_next;
    logic [QUEUE_W-1:0]    grant_queue_reg, grant_queue_next;
    logic                  release_reg, release_next;

    logic                  in_fire;
    pick_t                 pick;
    logic [TPB_W-1:0]      tpb;
    logic [BYTES_W-1:0]    byte_sum;
    logic [BYTES_W+TPB_W-1:0] frame_ticks;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;

    rrea_pick u_pick (
        .req           (queue_nonempty),
        .last_winner   (last_winner_reg),
        .active_queues (active_queues_reg),
        .pick          (pick)
    );

    always_comb
    begin
        tpb = ticks_per_byte_reg;
        if (tpb < TPB_W'(1))
        begin
            tpb = TPB_W'(1);
        end
        if (tpb > TPB_MAX)
        begin
            tpb = TPB_MAX;
        end
        byte_sum = BYTES_W'(frame_size) + BYTES_W'(overhead_bytes_reg)
                 + BYTES_W'(gap_bytes_reg);
        frame_ticks = (BYTES_W+TPB_W)'(byte_sum) * (BYTES_W+TPB_W)'(tpb);
    end

    always_comb
    begin
        last_winner_next = last_winner_reg;
        busy_next        = busy_reg;
        waiting_next     = waiting_reg;
        countdown_next   = countdown_reg;
        grant_valid_next = 1'b0;
        grant_queue_next = '0;
        release_next     = 1'b0;

        case (kind)
            KIND_LEVEL_RESP, KIND_LEVEL_UPDATE:
            begin
                if ((kind == KIND_LEVEL_RESP || !busy_reg) && pick.hit)
                begin
                    last_winner_next = pick.queue;
                    busy_next        = 1'b1;
                    grant_valid_next = 1'b1;
                    grant_queue_next = pick.queue;
                end
            end
            KIND_FRAME:
            begin
                // a newer frame simply reloads the timer
                countdown_next = frame_ticks[COUNT_W-1:0];
                waiting_next   = 1'b1;
                busy_next      = 1'b1;
            end
            KIND_TICK:
            begin
                if (waiting_reg)
                begin
                    if (countdown_reg <= COUNT_W'(1))
                    begin
                        countdown_next = '0;
                        waiting_next   = 1'b0;
                        busy_next      = 1'b0;
                        release_next   = 1'b1;
                    end
                    else
                    begin
                        countdown_next = countdown_reg - COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                countdown_next = countdown_reg;
            end
        endcase
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_queues_reg  <= ACTIVE_QUEUES_RST;
            overhead_bytes_reg <= OVERHEAD_BYTES_RST;
            gap_bytes_reg      <= GAP_BYTES_RST;
            ticks_per_byte_reg <= TICKS_PER_BYTE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACTIVE_QUEUES:  active_queues_reg  <= cfg_data[QCOUNT_W-1:0];
                CFG_OVERHEAD_BYTES: overhead_bytes_reg <= cfg_data[BYTE_CFG_W-1:0];
                CFG_GAP_BYTES:      gap_bytes_reg      <= cfg_data[BYTE_CFG_W-1:0];
                CFG_TICKS_PER_BYTE: ticks_per_byte_reg <= cfg_data[TPB_W-1:0];
                default:
                begin
                    active_queues_reg <= active_queues_reg;
                end
            endcase
        end
    end

    // arbiter and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_winner_reg <= LAST_WINNER_RST;
            busy_reg        <= 1'b0;
            waiting_reg     <= 1'b0;
            countdown_reg   <= '0;
        end
        else if (in_fire)
        begin
            last_winner_reg <= last_winner_next;
            busy_reg        <= busy_next;
            waiting_reg     <= waiting_next;
            countdown_reg   <= countdown_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            grant_valid_reg <= grant_valid_next;
            grant_queue_reg <= grant_queue_next;
            release_reg     <= release_next;
        end
    end

    logic busy_out_reg;
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            busy_out_reg <= busy_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign grant_valid   = grant_valid_reg;
    assign grant_queue   = grant_queue_reg;
    assign frame_release = release_reg;
    assign level_request = release_reg;
    assign busy_now      = busy_out_reg;

endmodule
